FILE: sv/ptsc_pkg.sv
// ptsc_pkg: widths, register indexes, controller states and command type
// for the pan/tilt slew controller. No dependencies.
package ptsc_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int ERR_W      = ANGLE_BITS + 1;
	localparam int GAIN_W     = 12;
	localparam int FRAC_W     = 16;
	localparam int DT_W       = 16;
	localparam int GAIN_FRAC  = 8;
	localparam int MUL_A_W    = ANGLE_BITS + GAIN_W;
	localparam int MUL_B_W    = 16;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int MOVE_SH    = GAIN_FRAC + DT_W;
	localparam int MOVE_W     = PROD_W + 1 - MOVE_SH;
	localparam int DELTA_W    = MOVE_W + 1;
	localparam int TSUM_W     = DELTA_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [GAIN_W-1:0] LAG_GAIN_RST      = GAIN_W'(1280);
	localparam logic [FRAC_W-1:0] STOP_FRACTION_RST = FRAC_W'(66);

	localparam logic [CFG_IDX_W-1:0] CFG_LAG_GAIN      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_FRACTION = CFG_IDX_W'(1);

	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_PAN  = 2'd1;
	localparam logic [1:0] STATUS_TILT = 2'd2;
	localparam logic [1:0] STATUS_BOTH = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_GAIN,
		ST_SCALE,
		ST_APPLY
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic span;
		logic gain;
		logic scale;
		logic apply;
	} ctrl_cmd_t;

	function automatic logic [ANGLE_BITS-1:0] abs_err(input logic signed [ERR_W:0] v);
		logic signed [ERR_W:0] m;
		begin
			m = v[ERR_W] ? -v : v;
			return m[ANGLE_BITS-1:0];
		end
	endfunction

endpackage

FILE: sv/ptsc_if.sv
// ptsc_if: valid/ready channel interfaces for items, results and config writes.
// Depends on ptsc_pkg.
interface ptsc_item_if import ptsc_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic signed [ANGLE_BITS-1:0] start_pan;
	logic signed [ANGLE_BITS-1:0] start_tilt;
	logic signed [ANGLE_BITS-1:0] target_pan;
	logic signed [ANGLE_BITS-1:0] target_tilt;
	logic        [DT_W-1:0]       step_time;

	modport source (output valid, mode, start_pan, start_tilt, target_pan, target_tilt,
		step_time, input ready);
	modport sink (input valid, mode, start_pan, start_tilt, target_pan, target_tilt,
		step_time, output ready);
endinterface

interface ptsc_result_if import ptsc_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic signed [ANGLE_BITS-1:0] pan_now;
	logic signed [ANGLE_BITS-1:0] tilt_now;

	modport source (output valid, status, pan_now, tilt_now, input ready);
	modport sink (input valid, status, pan_now, tilt_now, output ready);
endinterface

interface ptsc_cfg_if import ptsc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/ptsc_ctrl.sv
// ptsc_ctrl: sequencing state machine and result valid flag.
// Depends on ptsc_pkg; drives ptsc_dp through ctrl_cmd_t.
module ptsc_ctrl import ptsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_mode,
	output logic      item_ready,
	output logic      res_valid,
	input  logic      res_ready,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic        res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.apply) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = item_mode ? ST_APPLY : ST_SPAN;
				end
			end
			ST_SPAN: begin
				cmd.span = 1'b1;
				state_d  = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_APPLY;
			end
			ST_APPLY: begin
				// hold until the result register is free
				if (!res_valid_q || res_ready) begin
					cmd.apply = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

FILE: sv/ptsc_dp.sv
// ptsc_dp: angle state, config registers, per-axis multipliers and result register.
// Depends on ptsc_pkg; sequenced by ptsc_ctrl.
module ptsc_dp import ptsc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctrl_cmd_t                    cmd,
	input  logic                         in_mode,
	input  logic signed [ANGLE_BITS-1:0] in_start_pan,
	input  logic signed [ANGLE_BITS-1:0] in_start_tilt,
	input  logic signed [ANGLE_BITS-1:0] in_target_pan,
	input  logic signed [ANGLE_BITS-1:0] in_target_tilt,
	input  logic        [DT_W-1:0]       in_step_time,
	input  logic                         cfg_we,
	input  logic        [CFG_IDX_W-1:0]  cfg_index,
	input  logic        [CFG_DATA_W-1:0] cfg_data,
	output logic        [1:0]            status,
	output logic signed [ANGLE_BITS-1:0] pan_now,
	output logic signed [ANGLE_BITS-1:0] tilt_now
);

	localparam logic signed [ERR_W:0] HALF_W  = (ERR_W+1)'(2 ** (ANGLE_BITS - 1));
	localparam logic signed [ERR_W:0] TURN_W  = (ERR_W+1)'(2 ** ANGLE_BITS);
	localparam logic [PROD_W:0]       RND_HALF = (PROD_W+1)'(2 ** (MOVE_SH - 1));
	localparam logic signed [TSUM_W-1:0] T_MAX = TSUM_W'(2 ** (ANGLE_BITS - 1) - 1);
	localparam logic signed [TSUM_W-1:0] T_MIN = -TSUM_W'(2 ** (ANGLE_BITS - 1));

	logic                         mode_q;
	logic signed [ANGLE_BITS-1:0] sp_q, st_q, tp_q, tt_q;
	logic        [DT_W-1:0]       dt_q;
	logic signed [ANGLE_BITS-1:0] pan_q, tilt_q;
	logic        [GAIN_W-1:0]     lag_gain_q;
	logic        [FRAC_W-1:0]     stop_fraction_q;
	logic        [ANGLE_BITS-1:0] pe_q, te_q, pm_q, tm_q;
	logic                         psgn_q, tsgn_q;
	logic        [PROD_W-1:0]     prod_p_q, prod_t_q;
	logic                         pdone_q, tdone_q;
	logic        [1:0]            status_q;
	logic signed [ANGLE_BITS-1:0] pan_now_q, tilt_now_q;

	// fold on capture
	logic                         fold;
	logic signed [ANGLE_BITS-1:0] tilt_fold, pan_fold;

	assign fold      = !in_mode && tilt_q[ANGLE_BITS-1] && !tilt_q[ANGLE_BITS-2];
	assign tilt_fold = -tilt_q - {1'b1, {(ANGLE_BITS-1){1'b0}}};
	assign pan_fold  = {~pan_q[ANGLE_BITS-1], pan_q[ANGLE_BITS-2:0]};

	// errors and spans
	logic signed [ERR_W:0] perr, terr, pspan, tspan, perr_wr;

	assign perr  = (ERR_W+1)'(tp_q) - (ERR_W+1)'(pan_q);
	assign terr  = (ERR_W+1)'(tt_q) - (ERR_W+1)'(tilt_q);
	assign pspan = (ERR_W+1)'(sp_q) - (ERR_W+1)'(tp_q);
	assign tspan = (ERR_W+1)'(st_q) - (ERR_W+1)'(tt_q);

	always_comb begin
		perr_wr = perr;
		if (perr > HALF_W) begin
			perr_wr = perr - TURN_W;
		end else if (perr < -HALF_W) begin
			perr_wr = perr + TURN_W;
		end
	end

	// one multiplier per axis
	logic [MUL_A_W-1:0] pa, ta;
	logic [MUL_B_W-1:0] pb, tb;

	always_comb begin
		pa = MUL_A_W'(prod_p_q[MUL_A_W-1:0]);
		ta = MUL_A_W'(prod_t_q[MUL_A_W-1:0]);
		pb = dt_q;
		tb = dt_q;
		if (cmd.span) begin
			pa = MUL_A_W'(abs_err(pspan));
			ta = MUL_A_W'(abs_err(tspan));
			pb = stop_fraction_q;
			tb = stop_fraction_q;
		end else if (cmd.gain) begin
			pa = MUL_A_W'(pm_q);
			ta = MUL_A_W'(tm_q);
			pb = MUL_B_W'(lag_gain_q);
			tb = MUL_B_W'(lag_gain_q);
		end
	end

	// arrival test
	logic pdone, tdone;

	assign pdone = (sp_q == tp_q)
		|| ({pe_q, FRAC_W'(0)} < prod_p_q[ANGLE_BITS+FRAC_W-1:0]);
	assign tdone = (st_q == tt_q)
		|| ({te_q, FRAC_W'(0)} < prod_t_q[ANGLE_BITS+FRAC_W-1:0]);

	// move, rounded half away from zero
	logic [PROD_W:0]               prnd, trnd;
	logic signed [DELTA_W-1:0]     pdel, tdel;
	logic signed [ANGLE_BITS-1:0]  pan_mv, tilt_mv;
	logic signed [TSUM_W-1:0]      tsum;

	assign prnd = {1'b0, prod_p_q} + RND_HALF;
	assign trnd = {1'b0, prod_t_q} + RND_HALF;
	assign pdel = psgn_q ? -{1'b0, prnd[PROD_W:MOVE_SH]} : {1'b0, prnd[PROD_W:MOVE_SH]};
	assign tdel = tsgn_q ? -{1'b0, trnd[PROD_W:MOVE_SH]} : {1'b0, trnd[PROD_W:MOVE_SH]};
	assign pan_mv = pan_q + pdel[ANGLE_BITS-1:0];
	assign tsum   = TSUM_W'(tilt_q) + TSUM_W'(tdel);

	always_comb begin
		if (tsum > T_MAX) begin
			tilt_mv = T_MAX[ANGLE_BITS-1:0];
		end else if (tsum < T_MIN) begin
			tilt_mv = T_MIN[ANGLE_BITS-1:0];
		end else begin
			tilt_mv = tsum[ANGLE_BITS-1:0];
		end
	end

	// next angles and status at apply
	logic signed [ANGLE_BITS-1:0] pan_nx, tilt_nx;
	logic        [1:0]            status_nx;

	always_comb begin
		if (mode_q || (pdone_q && tdone_q)) begin
			pan_nx    = tp_q;
			tilt_nx   = tt_q;
			status_nx = STATUS_BOTH;
		end else begin
			pan_nx    = pan_mv;
			tilt_nx   = tilt_mv;
			status_nx = pdone_q ? STATUS_PAN : (tdone_q ? STATUS_TILT : STATUS_NONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q           <= '0;
			tilt_q          <= '0;
			lag_gain_q      <= LAG_GAIN_RST;
			stop_fraction_q <= STOP_FRACTION_RST;
		end else begin
			if (cfg_we && cfg_index == CFG_LAG_GAIN) begin
				lag_gain_q <= cfg_data[GAIN_W-1:0];
			end
			if (cfg_we && cfg_index == CFG_STOP_FRACTION) begin
				stop_fraction_q <= cfg_data[FRAC_W-1:0];
			end
			if (cmd.capture && fold) begin
				pan_q  <= pan_fold;
				tilt_q <= tilt_fold;
			end else if (cmd.apply) begin
				pan_q  <= pan_nx;
				tilt_q <= tilt_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			sp_q   <= in_start_pan;
			st_q   <= in_start_tilt;
			tp_q   <= in_target_pan;
			tt_q   <= in_target_tilt;
			dt_q   <= in_step_time;
		end
		if (cmd.span) begin
			pe_q   <= abs_err(perr);
			te_q   <= abs_err(terr);
			pm_q   <= abs_err(perr_wr);
			tm_q   <= abs_err(terr);
			psgn_q <= perr_wr[ERR_W];
			tsgn_q <= terr[ERR_W];
		end
		if (cmd.gain) begin
			pdone_q <= pdone;
			tdone_q <= tdone;
		end
		if (cmd.span || cmd.gain || cmd.scale) begin
			prod_p_q <= PROD_W'(pa) * PROD_W'(pb);
			prod_t_q <= PROD_W'(ta) * PROD_W'(tb);
		end
		if (cmd.apply) begin
			status_q   <= status_nx;
			pan_now_q  <= pan_nx;
			tilt_now_q <= tilt_nx;
		end
	end

	assign status   = status_q;
	assign pan_now  = pan_now_q;
	assign tilt_now = tilt_now_q;

endmodule

FILE: sv/pan_tilt_slew_controller_core.sv
// Pan/tilt slew controller top level: ptsc_ctrl sequences ptsc_dp.
// Depends on ptsc_pkg and the channel interfaces in ptsc_if.
//
//  channel  dir  beat carries
//  item     in   mode, start_pan, start_tilt, target_pan, target_tilt, step_time
//  result   out  status, pan_now, tilt_now
//  cfg      in   index, data (0 lag_gain, 1 stop_fraction)
//
// A slew step steps through accept, span multiply, gain multiply, time
// multiply and update, and its result is registered at the update; a load
// goes from accept straight to update. The three dependent multiplies on
// each axis's multiplier set this order. A new item is taken once the
// update is done, while the previous result may still wait. A held result
// stalls the update stage. Reset clears the angles and restores the config
// registers; cfg is always ready.
module pan_tilt_slew_controller_core import ptsc_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	ptsc_item_if.sink    item,
	ptsc_result_if.source result,
	ptsc_cfg_if.sink     cfg
);

	ctrl_cmd_t cmd;

	assign cfg.ready = 1'b1;

	ptsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_mode  (item.mode),
		.item_ready (item.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.cmd        (cmd)
	);

	ptsc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_mode        (item.mode),
		.in_start_pan   (item.start_pan),
		.in_start_tilt  (item.start_tilt),
		.in_target_pan  (item.target_pan),
		.in_target_tilt (item.target_tilt),
		.in_step_time   (item.step_time),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.status         (result.status),
		.pan_now        (result.pan_now),
		.tilt_now       (result.tilt_now)
	);

endmodule

FILE: sv/ptsc_chk.sv
// ptsc_chk: port-level assertions for the slew controller, bound to the top.
// Depends on ptsc_pkg.
module ptsc_chk import ptsc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_ready,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic [1:0]            res_status,
	input logic [ANGLE_BITS-1:0] res_pan,
	input logic [ANGLE_BITS-1:0] res_tilt,
	input logic                  cfg_ready
);

	// one item in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while busy");

	// a result only leaves the update stage
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!item_ready))
		else $error("result raised from idle");

	// held beat keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
			&& $stable(res_pan) && $stable(res_tilt))
		else $error("stalled result changed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind pan_tilt_slew_controller_core ptsc_chk u_ptsc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_status (result.status),
	.res_pan    (result.pan_now),
	.res_tilt   (result.tilt_now),
	.cfg_ready  (cfg.ready)
);
